[sv/tsbc_pkg.sv]
package tsbc_pkg;

   localparam logic [31:0] DELTA = 32'h9e37_79b9;

   localparam int KEY_WIDTH   = 32;
   localparam int HALF_WIDTH  = 32;
   localparam int CSR_IDX_W   = 2;

   // Register indexes on the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_WORD_0 = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_WORD_1 = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_WORD_2 = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_WORD_3 = 2'd3;

   // Operation codes carried on req_tuser.
   localparam logic FUNC_ENCRYPT = 1'b0;
   localparam logic FUNC_DECRYPT = 1'b1;

   typedef struct packed {
      logic [KEY_WIDTH-1:0] k0;
      logic [KEY_WIDTH-1:0] k1;
      logic [KEY_WIDTH-1:0] k2;
      logic [KEY_WIDTH-1:0] k3;
   } key_set_type;

   typedef struct packed {
      logic                  func;
      logic [HALF_WIDTH-1:0] h1;
      logic [HALF_WIDTH-1:0] h0;
   } item_type;

   typedef struct packed {
      logic [HALF_WIDTH-1:0] h1;
      logic [HALF_WIDTH-1:0] h0;
   } result_type;

endpackage

[sv/tsbc_half_round.sv]
module tsbc_half_round #(
   parameter int ROUNDS = 32,
   parameter int STEP   = 0
) (
   input  tsbc_pkg::item_type    item_i,
   input  tsbc_pkg::key_set_type keys_i,
   output tsbc_pkg::item_type    item_o
);

   // Encryption updates half 0 on even steps and half 1 on odd steps;
   // decryption walks the rounds backwards, so the order is swapped.
   localparam int          ENC_MULT = STEP / 2 + STEP % 2;
   localparam int          DEC_MULT = ROUNDS - STEP / 2 - STEP % 2;
   localparam logic [63:0] ENC_PROD = 64'(ENC_MULT) * 64'(tsbc_pkg::DELTA);
   localparam logic [63:0] DEC_PROD = 64'(DEC_MULT) * 64'(tsbc_pkg::DELTA);
   localparam logic [31:0] ENC_SUM  = ENC_PROD[31:0];
   localparam logic [31:0] DEC_SUM  = DEC_PROD[31:0];
   localparam logic        ODD_STEP = 1'((STEP % 2) != 0);

   logic        decrypt;
   logic        update_h0;
   logic [31:0] x;
   logic [31:0] target;
   logic [31:0] ka;
   logic [31:0] kb;
   logic [31:0] sum;
   logic [31:0] mix;
   logic [31:0] updated;

   always_comb begin
      decrypt   = (item_i.func == tsbc_pkg::FUNC_DECRYPT);
      update_h0 = (ODD_STEP == decrypt);
      x         = update_h0 ? item_i.h1 : item_i.h0;
      target    = update_h0 ? item_i.h0 : item_i.h1;
      ka        = update_h0 ? keys_i.k0 : keys_i.k2;
      kb        = update_h0 ? keys_i.k1 : keys_i.k3;
      sum       = decrypt ? DEC_SUM : ENC_SUM;
      mix       = ((x << 4) + ka) ^ (x + sum) ^ ((x >> 5) + kb);
      updated   = decrypt ? (target - mix) : (target + mix);

      item_o      = item_i;
      if (update_h0) begin
         item_o.h0 = updated;
      end else begin
         item_o.h1 = updated;
      end
   end

endmodule

[sv/tsbc_out_skid.sv]
module tsbc_out_skid (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   input  tsbc_pkg::result_type   in_data,
   output logic                   full,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [63:0]            rsp_tdata   // result_low [31:0], result_high [63:32]
);

   logic                 out_valid_ff;
   logic                 out_valid_in;
   tsbc_pkg::result_type out_data_ff;
   tsbc_pkg::result_type out_data_in;
   logic                 skid_valid_ff;
   logic                 skid_valid_in;
   tsbc_pkg::result_type skid_data_ff;
   tsbc_pkg::result_type skid_data_in;
   logic                 out_free;

   // The skid register catches the one result that arrives while the output
   // register is stalled; the pipeline is frozen as long as it is occupied.
   always_comb begin
      out_free      = rsp_tready || !out_valid_ff;
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (out_free) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = in_valid;
            out_data_in  = in_data;
         end
      end else if (in_valid) begin
         skid_valid_in = 1'b1;
         skid_data_in  = in_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign full       = skid_valid_ff;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {out_data_ff.h1, out_data_ff.h0};

endmodule

[sv/tea_style_block_cipher_unit.sv]
// TEA-style 64-bit block cipher engine with a 128-bit key.
// Requests arrive on the req_ stream: req_tdata carries the block as two
// 32-bit little-endian halves and req_tuser selects encrypt (0) or decrypt (1).
// Results leave on the rsp_ stream as the two processed halves, in order.
// The key is loaded through the csr_ write port, one 32-bit word per index,
// and should only change while no request is in flight.
// Each Feistel round is split into two half-rounds, one register stage each,
// so the datapath is 2*ROUNDS stages deep; a result passes through every
// stage and then the output register before it appears on rsp_tvalid.
// Throughput is one block per cycle for as long as the receiver keeps
// rsp_tready high; each stage holds a single half-round of logic.
// Reset clears the key words to zero and empties the pipeline and the output.
// When the receiver stalls, the output register holds its result and a skid
// register takes the next one; the whole pipeline then freezes and req_tready
// drops until the skid register drains, so nothing is lost or repeated.
module tea_style_block_cipher_unit #(
   parameter int ROUNDS = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // block_low [31:0], block_high [63:32]
   input  logic        req_tuser,   // func [0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // result_low [31:0], result_high [63:32]
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   localparam int STEPS = 2 * ROUNDS;

   tsbc_pkg::key_set_type keys_ff;
   tsbc_pkg::key_set_type keys_in;

   logic                  stage_valid_ff [STEPS];
   logic                  stage_valid_in [STEPS];
   tsbc_pkg::item_type    stage_ff       [STEPS];
   tsbc_pkg::item_type    stage_in       [STEPS];
   tsbc_pkg::item_type    step_out       [STEPS];

   logic                  advance;
   logic                  skid_full;
   tsbc_pkg::result_type  last_result;

   always_comb begin
      keys_in = keys_ff;
      if (csr_we) begin
         case (csr_index)
            tsbc_pkg::CSR_KEY_WORD_0: keys_in.k0 = csr_wdata;
            tsbc_pkg::CSR_KEY_WORD_1: keys_in.k1 = csr_wdata;
            tsbc_pkg::CSR_KEY_WORD_2: keys_in.k2 = csr_wdata;
            tsbc_pkg::CSR_KEY_WORD_3: keys_in.k3 = csr_wdata;
            default: keys_in = keys_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         keys_ff <= '0;
      end else begin
         keys_ff <= keys_in;
      end
   end

   assign advance    = !skid_full;
   assign req_tready = advance;

   always_comb begin
      stage_valid_in[0] = req_tvalid;
      stage_in[0].func  = req_tuser;
      stage_in[0].h0    = req_tdata[31:0];
      stage_in[0].h1    = req_tdata[63:32];
      for (int s = 1; s < STEPS; s++) begin
         stage_valid_in[s] = stage_valid_ff[s-1];
         stage_in[s]       = step_out[s-1];
      end
   end

   genvar g;
   generate
      for (g = 0; g < STEPS; g++) begin : g_step
         tsbc_half_round #(
            .ROUNDS(ROUNDS),
            .STEP  (g)
         ) u_half_round (
            .item_i(stage_ff[g]),
            .keys_i(keys_ff),
            .item_o(step_out[g])
         );

         always_ff @(posedge clock) begin
            if (reset) begin
               stage_valid_ff[g] <= 1'b0;
            end else if (advance) begin
               stage_valid_ff[g] <= stage_valid_in[g];
            end
         end

         always_ff @(posedge clock) begin
            if (advance) begin
               stage_ff[g] <= stage_in[g];
            end
         end
      end
   endgenerate

   assign last_result.h0 = step_out[STEPS-1].h0;
   assign last_result.h1 = step_out[STEPS-1].h1;

   tsbc_out_skid u_out_skid (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (stage_valid_ff[STEPS-1] && advance),
      .in_data   (last_result),
      .full      (skid_full),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata)
   );

endmodule

[dv/tea_style_block_cipher_unit_tb.sv]
module tea_style_block_cipher_unit_tb;

   localparam int CIPHER_ROUNDS = 32;
   localparam int STALL_LIMIT   = 5000;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata  = '0;   // block_low [31:0], block_high [63:32]
   logic        req_tuser  = tsbc_pkg::FUNC_ENCRYPT;   // func [0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;         // result_low [31:0], result_high [63:32]
   logic        csr_we     = 1'b0;
   logic [1:0]  csr_index  = tsbc_pkg::CSR_KEY_WORD_0;
   logic [31:0] csr_wdata  = '0;

   logic [31:0] key_mirror [4] = '{default: '0};
   logic [63:0] pending_blocks [$];
   int          mismatches      = 0;
   int          quiet_cycles    = 0;
   int          hold_off_cycles = 0;
   bit          bursts_enabled  = 1'b1;

   tea_style_block_cipher_unit #(
      .ROUNDS(CIPHER_ROUNDS)
   ) DUT (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic logic [31:0] feistel_mix(logic [31:0] x, logic [31:0] s,
                                               logic [31:0] ka, logic [31:0] kb);
      return ((x << 4) + ka) ^ (x + s) ^ ((x >> 5) + kb);
   endfunction

   // Expected processed block, high half in the upper word, under the current key.
   function automatic logic [63:0] tea_transform(logic func, logic [31:0] lo,
                                                 logic [31:0] hi);
      logic [31:0] h0;
      logic [31:0] h1;
      logic [31:0] sum;
      h0 = lo;
      h1 = hi;
      if (func == tsbc_pkg::FUNC_ENCRYPT) begin
         sum = '0;
         for (int r = 0; r < CIPHER_ROUNDS; r++) begin
            h0  = h0 + feistel_mix(h1, sum, key_mirror[0], key_mirror[1]);
            sum = sum + tsbc_pkg::DELTA;
            h1  = h1 + feistel_mix(h0, sum, key_mirror[2], key_mirror[3]);
         end
      end else begin
         sum = tsbc_pkg::DELTA * 32'(CIPHER_ROUNDS);
         for (int r = 0; r < CIPHER_ROUNDS; r++) begin
            h1  = h1 - feistel_mix(h0, sum, key_mirror[2], key_mirror[3]);
            sum = sum - tsbc_pkg::DELTA;
            h0  = h0 - feistel_mix(h1, sum, key_mirror[0], key_mirror[1]);
         end
      end
      return {h1, h0};
   endfunction

   function automatic logic [31:0] pick_half();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return '1;
         2: return 32'h1 << $urandom_range(0, 31);
         default: return $urandom;
      endcase
   endfunction

   // Writes all four key words on consecutive edges; the block must be idle.
   task automatic load_key(input logic [31:0] k0, input logic [31:0] k1,
                           input logic [31:0] k2, input logic [31:0] k3);
      logic [31:0] words [4];
      logic [1:0]  indexes [4];
      words   = '{k0, k1, k2, k3};
      indexes = '{tsbc_pkg::CSR_KEY_WORD_0, tsbc_pkg::CSR_KEY_WORD_1,
                  tsbc_pkg::CSR_KEY_WORD_2, tsbc_pkg::CSR_KEY_WORD_3};
      for (int i = 0; i < 4; i++) begin
         csr_we    <= 1'b1;
         csr_index <= indexes[i];
         csr_wdata <= words[i];
         key_mirror[indexes[i]] = words[i];
         @(posedge clock);
      end
      csr_we <= 1'b0;
   endtask

   task automatic send_block(input logic func, input logic [31:0] lo, input logic [31:0] hi);
      req_tvalid <= 1'b1;
      req_tuser  <= func;
      req_tdata  <= {hi, lo};
      do @(posedge clock); while (req_tready !== 1'b1);
      pending_blocks.push_back(tea_transform(func, lo, hi));
   endtask

   task automatic send_random_blocks(input int count, input bit with_gaps);
      for (int i = 0; i < count; i++) begin
         if (with_gaps && bursts_enabled && $urandom_range(0, 5) == 0) begin
            req_tvalid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clock);
         end
         send_block(1'($urandom_range(0, 1)), pick_half(), pick_half());
      end
      req_tvalid <= 1'b0;
   endtask

   task automatic wait_for_results();
      while (pending_blocks.size() != 0) @(posedge clock);
   endtask

   // The key must read as zero straight after reset.
   task automatic test_reset_key();
      send_block(tsbc_pkg::FUNC_ENCRYPT, 32'h0000_0000, 32'h0000_0000);
      send_block(tsbc_pkg::FUNC_DECRYPT, 32'h0000_0000, 32'h0000_0000);
      send_block(tsbc_pkg::FUNC_ENCRYPT, 32'hffff_ffff, 32'hffff_ffff);
      send_block(tsbc_pkg::FUNC_DECRYPT, 32'hffff_ffff, 32'hffff_ffff);
      send_block(tsbc_pkg::FUNC_ENCRYPT, 32'h5555_5555, 32'haaaa_aaaa);
      send_block(tsbc_pkg::FUNC_DECRYPT, 32'haaaa_aaaa, 32'h5555_5555);
      req_tvalid <= 1'b0;
      wait_for_results();
   endtask

   task automatic test_directed();
      logic [63:0] plain [3];
      logic [63:0] cipher;
      plain = '{64'h0000_0000_0000_0000, 64'hffff_ffff_ffff_ffff, 64'h0123_4567_89ab_cdef};
      load_key('1, '1, '1, '1);
      send_block(tsbc_pkg::FUNC_ENCRYPT, 32'h0000_0000, 32'h0000_0000);
      send_block(tsbc_pkg::FUNC_DECRYPT, 32'hffff_ffff, 32'hffff_ffff);
      send_block(tsbc_pkg::FUNC_ENCRYPT, 32'h8000_0000, 32'h0000_0001);
      send_block(tsbc_pkg::FUNC_DECRYPT, 32'h0000_0001, 32'h8000_0000);
      req_tvalid <= 1'b0;
      wait_for_results();
      // Round trips: a ciphertext sent back for decryption must return the plaintext.
      load_key(32'h0123_4567, 32'h89ab_cdef, 32'hfedc_ba98, 32'h7654_3210);
      for (int i = 0; i < 3; i++) begin
         cipher = tea_transform(tsbc_pkg::FUNC_ENCRYPT, plain[i][31:0], plain[i][63:32]);
         send_block(tsbc_pkg::FUNC_ENCRYPT, plain[i][31:0], plain[i][63:32]);
         send_block(tsbc_pkg::FUNC_DECRYPT, cipher[31:0], cipher[63:32]);
      end
      req_tvalid <= 1'b0;
      wait_for_results();
   endtask

   task automatic test_key_sweep();
      logic [31:0] k [4];
      for (int s = 0; s < 6; s++) begin
         for (int w = 0; w < 4; w++) begin
            case (s)
               0: k[w] = '0;
               1: k[w] = '1;
               2: k[w] = 32'h1 << $urandom_range(0, 31);
               3: k[w] = (w % 2 == 0) ? 32'haaaa_aaaa : 32'h5555_5555;
               default: k[w] = $urandom;
            endcase
         end
         load_key(k[0], k[1], k[2], k[3]);
         send_random_blocks(180, 1'b1);
         wait_for_results();
      end
   endtask

   // The receiver holds off long enough for the pipeline to fill and stall requests.
   task automatic test_back_pressure();
      load_key($urandom, $urandom, $urandom, $urandom);
      hold_off_cycles = 400;
      send_random_blocks(150, 1'b0);
      wait_for_results();
   endtask

   task automatic test_streaming();
      bursts_enabled = 1'b0;
      load_key($urandom, $urandom, $urandom, $urandom);
      send_random_blocks(300, 1'b0);
      wait_for_results();
   endtask

   initial begin
      forever begin
         if (hold_off_cycles > 0) begin
            rsp_tready <= 1'b0;
            repeat (hold_off_cycles) @(posedge clock);
            hold_off_cycles = 0;
         end else if (bursts_enabled && $urandom_range(0, 7) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin
      logic [63:0] expected_block;
      if (!reset) begin
         if ((req_tvalid && req_tready === 1'b1) || (rsp_tvalid === 1'b1 && rsp_tready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
         end
         if (rsp_tvalid === 1'b1 && rsp_tready) begin
            if (pending_blocks.size() == 0) begin
               $error("result with no request outstanding: %h", rsp_tdata);
               mismatches++;
            end else begin
               expected_block = pending_blocks.pop_front();
               if (rsp_tdata[31:0] !== expected_block[31:0]) begin
                  $error("result_low: expected %h, actual %h",
                         expected_block[31:0], rsp_tdata[31:0]);
                  mismatches++;
               end
               if (rsp_tdata[63:32] !== expected_block[63:32]) begin
                  $error("result_high: expected %h, actual %h",
                         expected_block[63:32], rsp_tdata[63:32]);
                  mismatches++;
               end
            end
         end
      end
   end

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_reset_key();
      test_directed();
      test_key_sweep();
      test_back_pressure();
      test_streaming();
      wait_for_results();
      repeat (2 * CIPHER_ROUNDS + 10) @(posedge clock);
      if (mismatches == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
